// ===== design/dqkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqkr_pkg
// Shared types, codes and sizes of the double-ended queue with key removal.
// ----------------------------------------------------------------------------
package dqkr_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE_KEY = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_KEY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch_item;
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
        logic pop_capture;
        logic set_full;
        logic set_empty;
        logic scan_init;
        logic scan_read;
        logic scan_check;
        logic scan_finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              scan_last;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/dqkr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqkr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dqkr_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/dqkr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqkr_ctrl
// Controller state machine: sequences push, pop and key removal commands.
// ----------------------------------------------------------------------------
module dqkr_ctrl
    import dqkr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.mode)
                    MODE_PUSH_FRONT:
                    begin
                        cmd.set_full   = sts.full;
                        cmd.push_front = !sts.full;
                    end
                    MODE_PUSH_REAR:
                    begin
                        cmd.set_full  = sts.full;
                        cmd.push_rear = !sts.full;
                    end
                    MODE_POP_FRONT:
                    begin
                        cmd.set_empty = sts.empty;
                        cmd.pop_front = !sts.empty;
                        if (!sts.empty)
                        begin
                            state_next = S_POP_WAIT;
                        end
                    end
                    MODE_POP_REAR:
                    begin
                        cmd.set_empty = sts.empty;
                        cmd.pop_rear  = !sts.empty;
                        if (!sts.empty)
                        begin
                            state_next = S_POP_WAIT;
                        end
                    end
                    MODE_REMOVE_KEY:
                    begin
                        cmd.set_empty = sts.empty;
                        cmd.scan_init = !sts.empty;
                        if (!sts.empty)
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.pop_capture = 1'b1;
                state_next      = S_DONE;
            end
            S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
                state_next    = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
                state_next     = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                cmd.scan_finish = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dqkr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqkr_dp
// Datapath: ring pointers, entry store, key scan counters and result words.
// ----------------------------------------------------------------------------
module dqkr_dp
    import dqkr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output sts_t                          sts,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic [COUNT_W-1:0]            removed_count,
    output logic [COUNT_W-1:0]            length
);

    localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= CAP_EXT)
        begin
            sum = sum - CAP_EXT;
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [PTR_W-1:0]        fp_reg;
    logic [PTR_W-1:0]        fp_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [MODE_W-1:0]       mode_reg;
    logic [DATA_W-1:0]       value_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        kept_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [DATA_W-1:0]       res_value_reg;
    logic [CNT_W-1:0]        res_count_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [DATA_W-1:0]       out_value_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic [CNT_W-1:0]        out_length_reg;

    logic                    ram_we;
    logic [PTR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [PTR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]       ram_rdata;
    logic [PTR_W-1:0]        fp_dec;
    logic [PTR_W-1:0]        fp_inc;
    logic                    keep_entry;

    dqkr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign fp_dec     = (fp_reg == '0) ? PTR_LAST : fp_reg - 1'b1;
    assign fp_inc     = (fp_reg == PTR_LAST) ? '0 : fp_reg + 1'b1;
    assign keep_entry = (ram_rdata != value_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot(fp_reg, kept_reg);
        ram_wdata = ram_rdata;
        ram_raddr = fp_reg;
        fp_next   = fp_reg;
        cnt_next  = cnt_reg;
        if (cmd.push_front)
        begin
            ram_we    = 1'b1;
            ram_waddr = fp_dec;
            ram_wdata = value_reg;
            fp_next   = fp_dec;
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (cmd.push_rear)
        begin
            ram_we    = 1'b1;
            ram_waddr = slot(fp_reg, cnt_reg);
            ram_wdata = value_reg;
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (cmd.pop_front)
        begin
            ram_raddr = fp_reg;
            fp_next   = fp_inc;
            cnt_next  = cnt_reg - 1'b1;
        end
        else if (cmd.pop_rear)
        begin
            ram_raddr = slot(fp_reg, cnt_reg - 1'b1);
            cnt_next  = cnt_reg - 1'b1;
        end
        else if (cmd.scan_read)
        begin
            ram_raddr = slot(fp_reg, idx_reg);
        end
        else if (cmd.scan_check)
        begin
            ram_we = keep_entry;
        end
        else if (cmd.scan_finish)
        begin
            cnt_next = kept_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fp_reg        <= fp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            mode_reg       <= mode;
            value_reg      <= value;
            res_status_reg <= STATUS_OK;
            res_value_reg  <= '0;
            res_count_reg  <= '0;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= STATUS_FULL;
        end
        if (cmd.set_empty)
        begin
            res_status_reg <= STATUS_EMPTY;
        end
        if (cmd.pop_front || cmd.pop_rear)
        begin
            res_count_reg <= CNT_W'(1);
        end
        if (cmd.pop_capture)
        begin
            res_value_reg <= ram_rdata;
        end
        if (cmd.scan_init)
        begin
            idx_reg  <= '0;
            kept_reg <= '0;
        end
        if (cmd.scan_check)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (keep_entry)
            begin
                kept_reg <= kept_reg + 1'b1;
            end
        end
        if (cmd.scan_finish)
        begin
            res_count_reg  <= cnt_reg - kept_reg;
            res_status_reg <= (cnt_reg == kept_reg) ? STATUS_NO_KEY : STATUS_OK;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= res_count_reg;
            out_length_reg <= cnt_reg;
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.full      = (cnt_reg == CNT_FULL);
    assign sts.empty     = (cnt_reg == '0);
    assign sts.scan_last = (idx_reg == cnt_reg - 1'b1);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign removed_value = out_value_reg;
    assign removed_count = COUNT_W'(out_count_reg);
    assign length        = COUNT_W'(out_length_reg);

endmodule

`default_nettype wire

// ===== design/deque_with_key_removal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_key_removal
// Bounded double-ended queue of signed words with removal of all equal keys.
// ----------------------------------------------------------------------------
// One input channel (in_valid, in_stall, mode, value) and one result channel
// (out_valid, out_stall, status, removed_value, removed_count, length).
// Each input word gives exactly one result word, in order.
// Push front/rear: idle, execute and done states. Pop front/rear adds a wait
// state for the RAM read, skipped on an empty queue. Remove by key: after
// execute, a read and a check state per entry held, then an end state; an
// empty queue goes straight to done. Each entry is read from the RAM, compared
// with the key and written back if kept. Unknown modes: nothing changes.
// The input is taken only while the controller is idle; a finished result
// sits in the output register, so the next word is accepted while the
// receiver stalls. A second result waits in the datapath until the output
// register frees up, and the input stays stalled meanwhile.
// Reset empties the queue and clears out_valid; the entry RAM is not
// cleared, since only entries written earlier are ever read.
// ----------------------------------------------------------------------------
module deque_with_key_removal
    import dqkr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [STATUS_W-1:0]           status,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic [COUNT_W-1:0]            removed_count,
    output logic [COUNT_W-1:0]            length
);

    cmd_t cmd;
    sts_t sts;

    dqkr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dqkr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .removed_count (removed_count),
        .length        (length)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a word");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_EMPTY) |-> (removed_count == '0 && length == '0))
        else $error("empty status with nonzero count or length");

    a_value_with_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && removed_value != '0) |-> (removed_count == COUNT_W'(1)))
        else $error("removed value without a single removal");

    a_no_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_NO_KEY || status == STATUS_FULL))
            |-> (removed_count == '0))
        else $error("entries removed with full or no-key status");
`endif

endmodule

`default_nettype wire

// ===== verif/dqkr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqkr_checker
// Watches both channels of the deque, keeps its own copy of the ring, the
// front index and the fill level, works out the result of every accepted
// input word and compares each accepted result word field by field with the
// oldest expected one. Reports the failure count and the number of results
// still outstanding.
// ----------------------------------------------------------------------------
module dqkr_checker
    import dqkr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [STATUS_W-1:0]      status,
    input  wire logic signed [DATA_W-1:0] removed_value,
    input  wire logic [COUNT_W-1:0]       removed_count,
    input  wire logic [COUNT_W-1:0]       length,
    output int                            fail_count,
    output int                            pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [DATA_W-1:0]   removed_value;
        logic [COUNT_W-1:0]         removed_count;
        logic [COUNT_W-1:0]         length;
    } result_t;

    logic signed [DATA_W-1:0] ring [CAPACITY];
    int                       front_idx;
    int                       held;
    int                       mismatches;
    result_t                  pending_results [$];

    function automatic result_t apply_word(input logic [MODE_W-1:0] m,
                                           input logic signed [DATA_W-1:0] v);
        result_t                  r;
        int                       kept;
        logic signed [DATA_W-1:0] e;
        r = '0;
        case (m)
            MODE_PUSH_FRONT:
            begin
                if (held == CAPACITY)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    front_idx = (front_idx + CAPACITY - 1) % CAPACITY;
                    ring[front_idx] = v;
                    held++;
                end
            end
            MODE_PUSH_REAR:
            begin
                if (held == CAPACITY)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    ring[(front_idx + held) % CAPACITY] = v;
                    held++;
                end
            end
            MODE_POP_FRONT:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.removed_value = ring[front_idx];
                    r.removed_count = COUNT_W'(1);
                    front_idx = (front_idx + 1) % CAPACITY;
                    held--;
                end
            end
            MODE_POP_REAR:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.removed_value = ring[(front_idx + held - 1) % CAPACITY];
                    r.removed_count = COUNT_W'(1);
                    held--;
                end
            end
            MODE_REMOVE_KEY:
            begin
                if (held == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    // survivors slide toward the front, order kept
                    kept = 0;
                    for (int i = 0; i < held; i++)
                    begin
                        e = ring[(front_idx + i) % CAPACITY];
                        if (e != v)
                        begin
                            ring[(front_idx + kept) % CAPACITY] = e;
                            kept++;
                        end
                    end
                    r.removed_count = COUNT_W'(held - kept);
                    if (kept == held)
                        r.status = STATUS_NO_KEY;
                    held = kept;
                end
            end
            default:
            begin
            end
        endcase
        r.length = COUNT_W'(held);
        return r;
    endfunction

    task automatic check_result();
        result_t want;
        result_t got;
        got.status        = status;
        got.removed_value = removed_value;
        got.removed_count = removed_count;
        got.length        = length;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected word: status %0d value %0d count %0d length %0d",
                         $time, got.status, got.removed_value, got.removed_count, got.length);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.removed_value !== want.removed_value ||
                got.removed_count !== want.removed_count || got.length !== want.length)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: expected status %0d value %0d count %0d length %0d",
                             $time, want.status, want.removed_value, want.removed_count,
                             want.length);
                    $display("%0t:   actual status %0d value %0d count %0d length %0d",
                             $time, got.status, got.removed_value, got.removed_count,
                             got.length);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx = 0;
            held = 0;
            mismatches = 0;
            pending_results.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                pending_results.push_back(apply_word(mode, value));
            fail_count <= mismatches;
            pending <= pending_results.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the deque with directed corner words (empty and full queue, extreme
// values, unknown modes, key hits and misses) and then with random runs that
// fill, drain and flush the queue, with random input gaps and output stalls.
// The checker beside the block predicts and compares; this module only makes
// stimulus, guards against hangs and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import dqkr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    localparam int                RANDOM_WORDS   = 900;
    localparam int                POOL_SIZE      = 6;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                DRAIN_CYCLES   = 60;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       removed_count;
    logic [COUNT_W-1:0]       length;
    int                       fail_count;
    int                       pending;

    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
    int                       words_sent;
    logic                     burst_mode = 1'b0;
    int                       idle_cycles = 0;
    int                       hold_left = 0;
    int                       stall_pick;
    logic                     stall_now = 1'b0;

    deque_with_key_removal dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .removed_count (removed_count),
        .length        (length)
    );

    dqkr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .removed_count (removed_count),
        .length        (length),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver stalls: mostly short, a few long, with stall-free stretches
    always @(posedge clk)
    begin
        if (hold_left == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55)
            begin
                stall_now = 1'b0;
                hold_left = 1;
            end
            else if (stall_pick < 85)
            begin
                stall_now = 1'b1;
                hold_left = $urandom_range(1, 3);
            end
            else if (stall_pick < 95)
            begin
                stall_now = 1'b0;
                hold_left = $urandom_range(30, 150);
            end
            else
            begin
                stall_now = 1'b1;
                hold_left = $urandom_range(10, 40);
            end
        end
        hold_left--;
        out_stall <= stall_now;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic send_word(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (m <= MODE_REMOVE_KEY)
            words_sent++;
    endtask

    task automatic send_push(input logic signed [DATA_W-1:0] v);
        send_word($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, v);
    endtask

    task automatic send_pop();
        send_word($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR, pick_value(50));
    endtask

    task automatic run_segment();
        int                       kind;
        int                       push_pct;
        int                       pop_pct;
        int                       pick;
        logic signed [DATA_W-1:0] key;
        kind = $urandom_range(0, 9);
        burst_mode = ($urandom_range(0, 3) == 0);
        if (kind == 7)
        begin
            // empty the queue, fill it with one value, then flush it by key
            key = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            repeat (CAPACITY) send_pop();
            repeat (CAPACITY + 2) send_push(key);
            send_word(MODE_REMOVE_KEY, key);
        end
        else
        begin
            if (kind <= 3)
            begin
                push_pct = 80;
                pop_pct = 10;
            end
            else if (kind <= 6)
            begin
                push_pct = 10;
                pop_pct = 70;
            end
            else
            begin
                push_pct = 45;
                pop_pct = 35;
            end
            repeat ($urandom_range(4, 24))
            begin
                pick = $urandom_range(0, 99);
                if (kind == 8)
                    send_word(MODE_W'($urandom_range(0, 7)), pick_value(60));
                else if (pick < push_pct)
                    send_push(pick_value(60));
                else if (pick < push_pct + pop_pct)
                    send_pop();
                else
                    send_word(MODE_REMOVE_KEY, pick_value(80));
            end
        end
    endtask

    initial
    begin
        value_pool[0] = '0;
        value_pool[1] = -1;
        value_pool[2] = DATA_MIN;
        value_pool[3] = DATA_MAX;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom_range(1, 15);
        words_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue and unknown modes
        send_word(MODE_POP_FRONT, DATA_MAX);
        send_word(MODE_POP_REAR, DATA_MIN);
        send_word(MODE_REMOVE_KEY, '0);
        send_word(MODE_UNUSED_LO, -1);
        send_word(MODE_UNUSED_HI, DATA_MAX);

        // fill to capacity with extremes and repeats, then overfill
        send_word(MODE_PUSH_FRONT, DATA_MIN);
        send_word(MODE_PUSH_REAR, DATA_MAX);
        send_word(MODE_PUSH_REAR, -1);
        send_word(MODE_PUSH_FRONT, '0);
        for (int i = 0; i < CAPACITY - 4; i++)
            send_word(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                      (i % 3 == 0) ? -1 : ((i % 3 == 1) ? 32'sh5555_5555 : 32'shAAAA_AAAA));
        send_word(MODE_PUSH_REAR, 1);

        // key miss, key hit on several entries, pops at both ends
        send_word(MODE_REMOVE_KEY, 32'sh0000_3039);
        send_word(MODE_REMOVE_KEY, -1);
        send_word(MODE_POP_FRONT, '0);
        send_word(MODE_POP_REAR, '0);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
            run_segment();

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
